>>> hdl/xyz_sample_ascii_line_formatter_macros.svh
// Assertion macros shared by the checkers of the sample line formatter.
`ifndef XYZ_SAMPLE_ASCII_LINE_FORMATTER_MACROS_SVH
`define XYZ_SAMPLE_ASCII_LINE_FORMATTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define XLF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formatter check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define XLF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("formatter check failed");

`endif

>>> hdl/xlf_pkg.sv
// Types, character codes and helpers shared by the sample line formatter.
`timescale 1ns / 1ps

package xlf_pkg;

    localparam int AXIS_W     = 10;
    localparam int LINE_BYTES = 16;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Largest magnitude that still fits in three digits
    localparam logic [AXIS_W-1:0] MAX_MAG = 10'd999;

    // Reciprocal multipliers: n*41 >> 12 == n/100 for n < 1000,
    // r*103 >> 10 == r/10 for r < 100
    localparam logic [5:0] HUND_MUL = 6'd41;
    localparam logic [6:0] TENS_MUL = 7'd103;

    // Text of one axis: up to four characters, first one in the low byte
    typedef struct packed {
        logic [31:0] text;
        logic [2:0]  len;
    } field_t;

    // Load enables of the per-axis stages
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } axis_ctrl_t;

    // Pack sign and decimal digits into left-aligned text without leading zeros
    function automatic field_t axis_field(input logic neg, input logic [3:0] hund,
                                          input logic [3:0] tens, input logic [3:0] units);
        field_t     f;
        logic [2:0] n;
        f.text = '0;
        n      = '0;
        if (neg) begin
            f.text[7:0] = CH_MINUS;
            n = 3'd1;
        end
        if (hund != 4'd0) begin
            f.text[{n[1:0], 3'b000} +: 8] = CH_ZERO + {4'd0, hund};
            n = n + 3'd1;
        end
        if ((hund != 4'd0) || (tens != 4'd0)) begin
            f.text[{n[1:0], 3'b000} +: 8] = CH_ZERO + {4'd0, tens};
            n = n + 3'd1;
        end
        f.text[{n[1:0], 3'b000} +: 8] = CH_ZERO + {4'd0, units};
        f.len = n + 3'd1;
        return f;
    endfunction

endpackage

>>> hdl/xlf_axis.sv
// Three-stage decimal conversion of one axis: magnitude, hundreds, tens and units.
`timescale 1ns / 1ps

module xlf_axis (
    input  logic                            clk,
    input  xlf_pkg::axis_ctrl_t             ctrl,
    input  logic signed [xlf_pkg::AXIS_W-1:0] axis_raw,
    output xlf_pkg::field_t                 field
);
    import xlf_pkg::*;

    logic              neg1_reg, neg1_next;
    logic [AXIS_W-1:0] mag_reg, mag_next;
    logic              neg2_reg, neg2_next;
    logic [3:0]        hund_reg, hund_next;
    logic [6:0]        rem_reg, rem_next;
    field_t            field_reg, field_next;

    logic [AXIS_W-1:0] abs_val;
    logic [15:0]       hund_prod;
    logic [AXIS_W-1:0] hund_part;
    logic [13:0]       tens_prod;
    logic [3:0]        tens_dig;
    logic [6:0]        tens_part;
    logic [6:0]        units_diff;

    // Stage 1: sign and saturated magnitude
    always_comb
    begin
        neg1_next = axis_raw[AXIS_W-1];
        abs_val   = neg1_next ? (~axis_raw + 1'b1) : axis_raw;
        mag_next  = (abs_val > MAX_MAG) ? MAX_MAG : abs_val;
    end

    // Stage 2: hundreds digit by reciprocal multiply, keep the remainder
    always_comb
    begin
        neg2_next = neg1_reg;
        hund_prod = {6'd0, mag_reg} * {10'd0, HUND_MUL};
        hund_next = hund_prod[15:12];
        hund_part = {6'd0, hund_next} * 10'd100;
        rem_next  = 7'(mag_reg - hund_part);
    end

    // Stage 3: tens and units, then build the text
    always_comb
    begin
        tens_prod  = {7'd0, rem_reg} * {7'd0, TENS_MUL};
        tens_dig   = tens_prod[13:10];
        tens_part  = {3'd0, tens_dig} * 7'd10;
        units_diff = rem_reg - tens_part;
        field_next = axis_field(neg2_reg, hund_reg, tens_dig, units_diff[3:0]);
    end

    // Advance each stage when its load enable is high
    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            neg1_reg <= neg1_next;
            mag_reg  <= mag_next;
        end
        if (ctrl.en2)
        begin
            neg2_reg <= neg2_next;
            hund_reg <= hund_next;
            rem_reg  <= rem_next;
        end
        if (ctrl.en3)
        begin
            field_reg <= field_next;
        end
    end

    assign field = field_reg;

endmodule

>>> hdl/xlf_join.sv
// Joins the x and y texts with their commas and carries the z text along.
`timescale 1ns / 1ps

module xlf_join (
    input  logic            clk,
    input  logic            en,
    input  xlf_pkg::field_t x_field,
    input  xlf_pkg::field_t y_field,
    input  xlf_pkg::field_t z_field,
    output logic [79:0]     head_text,
    output logic [3:0]      head_len,
    output xlf_pkg::field_t tail_field
);
    import xlf_pkg::*;

    logic [79:0] head_reg, head_next;
    logic [3:0]  len_reg, len_next;
    field_t      z_reg;

    logic [3:0]  pos_y;
    logic [3:0]  pos_c2;

    // Place x, comma, y, comma at running byte offsets
    always_comb
    begin
        pos_y     = {1'b0, x_field.len} + 4'd1;
        pos_c2    = pos_y + {1'b0, y_field.len};
        len_next  = pos_c2 + 4'd1;
        head_next = {48'd0, x_field.text}
                  | ({72'd0, CH_COMMA} << {x_field.len, 3'b000})
                  | ({48'd0, y_field.text} << {pos_y, 3'b000})
                  | ({72'd0, CH_COMMA} << {pos_c2, 3'b000});
    end

    // Hold the joined head until the next load
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg <= head_next;
            len_reg  <= len_next;
            z_reg    <= z_field;
        end
    end

    assign head_text  = head_reg;
    assign head_len   = len_reg;
    assign tail_field = z_reg;

endmodule

>>> hdl/xlf_serial.sv
// Completes the line with z, LF and CR and shifts it out a byte a cycle unless stalled.
`timescale 1ns / 1ps

module xlf_serial (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            line_valid,
    input  logic [79:0]     head_text,
    input  logic [3:0]      head_len,
    input  xlf_pkg::field_t tail_field,
    output logic            can_load,
    output logic            text_valid,
    input  logic            text_stall,
    output logic [7:0]      text_byte,
    output logic            line_end
);
    import xlf_pkg::*;

    logic [LINE_BYTES*8-1:0] buf_reg, buf_next;
    logic [4:0]              cnt_reg, cnt_next;

    logic [47:0]             tail_text;
    logic [LINE_BYTES*8-1:0] line_text;
    logic [4:0]              line_len;
    logic                    take;
    logic                    load;

    // Append z and the line ending behind the head
    always_comb
    begin
        tail_text = {16'd0, tail_field.text}
                  | ({40'd0, CH_LF} << {tail_field.len, 3'b000})
                  | ({40'd0, CH_CR} << {tail_field.len + 3'd1, 3'b000});
        line_text = {48'd0, head_text} | ({80'd0, tail_text} << {head_len, 3'b000});
        line_len  = {1'b0, head_len} + {2'b00, tail_field.len} + 5'd2;
    end

    // Load a new line when empty or as the last byte leaves, else shift on each transaction
    always_comb
    begin
        take     = (cnt_reg != 5'd0) && !text_stall;
        can_load = (cnt_reg == 5'd0) || ((cnt_reg == 5'd1) && take);
        load     = can_load && line_valid;
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = line_text;
            cnt_next = line_len;
        end
        else if (take)
        begin
            buf_next = buf_reg >> 8;
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign text_valid = (cnt_reg != 5'd0);
    assign text_byte  = buf_reg[7:0];
    assign line_end   = (cnt_reg == 5'd1);

endmodule

>>> hdl/xyz_sample_ascii_line_formatter.sv
// Top level of the three-axis sample to ASCII text line formatter.
//
// Each accepted sample (x, y, z) leaves as one text line, one byte per
// transaction: "x,y,z" in decimal without leading zeros, '-' before negative
// values, then newline and carriage return, with line_end high on the carriage
// return. Values are saturated to -999..999. A line is 7 to 16 bytes long and
// the output port moves one byte per cycle while text_stall is low, so that
// byte-wide port sets the sustained rate; the pipeline ahead of it (three
// conversion stages, one join stage, the shift buffer) takes a new sample
// every cycle while it has room. A sample passes the conversion stages and
// the join stage before its line is loaded into the shift buffer and its
// first byte is on the output. No state carries from one line to the next.
`timescale 1ns / 1ps

module xyz_sample_ascii_line_formatter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic signed [xlf_pkg::AXIS_W-1:0] axis_x,
    input  logic signed [xlf_pkg::AXIS_W-1:0] axis_y,
    input  logic signed [xlf_pkg::AXIS_W-1:0] axis_z,
    output logic                              text_valid,
    input  logic                              text_stall,
    output logic [7:0]                        text_byte,
    output logic                              line_end
);
    import xlf_pkg::*;

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       v1_next, v2_next, v3_next, v4_next;
    logic       en4;
    logic       can_load;
    axis_ctrl_t ctrl;

    field_t      x_field, y_field, z_field, tail_field;
    logic [79:0] head_text;
    logic [3:0]  head_len;

    // Stage enables: a stage loads when empty or when its content moves on
    always_comb
    begin
        en4      = !v4_reg || can_load;
        ctrl.en3 = !v3_reg || en4;
        ctrl.en2 = !v2_reg || ctrl.en3;
        ctrl.en1 = !v1_reg || ctrl.en2;
        sample_stall = !ctrl.en1;
        v1_next = ctrl.en1 ? sample_valid : v1_reg;
        v2_next = ctrl.en2 ? v1_reg : v2_reg;
        v3_next = ctrl.en3 ? v2_reg : v3_reg;
        v4_next = en4 ? v3_reg : v4_reg;
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    xlf_axis u_axis_x (
        .clk      (clk),
        .ctrl     (ctrl),
        .axis_raw (axis_x),
        .field    (x_field)
    );

    xlf_axis u_axis_y (
        .clk      (clk),
        .ctrl     (ctrl),
        .axis_raw (axis_y),
        .field    (y_field)
    );

    xlf_axis u_axis_z (
        .clk      (clk),
        .ctrl     (ctrl),
        .axis_raw (axis_z),
        .field    (z_field)
    );

    xlf_join u_join (
        .clk        (clk),
        .en         (en4),
        .x_field    (x_field),
        .y_field    (y_field),
        .z_field    (z_field),
        .head_text  (head_text),
        .head_len   (head_len),
        .tail_field (tail_field)
    );

    xlf_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (v4_reg),
        .head_text  (head_text),
        .head_len   (head_len),
        .tail_field (tail_field),
        .can_load   (can_load),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_byte  (text_byte),
        .line_end   (line_end)
    );

endmodule

>>> hdl/xlf_checker.sv
// Port-level checks of the sample line formatter and their bind.
`timescale 1ns / 1ps
`include "xyz_sample_ascii_line_formatter_macros.svh"

module xlf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       sample_valid,
    input logic       sample_stall,
    input logic       text_valid,
    input logic       text_stall,
    input logic [7:0] text_byte,
    input logic       line_end
);
    import xlf_pkg::*;

    logic cr_match;
    logic lf_take;
    logic in_busy;

    assign cr_match = (text_byte == CH_CR) == line_end;
    assign lf_take  = text_valid && !text_stall && (text_byte == CH_LF);
    assign in_busy  = sample_valid && sample_stall;

    // A stalled byte holds
    `XLF_ASSERT_NEXT(a_out_hold, text_valid && text_stall,
        text_valid && $stable(text_byte) && $stable(line_end))
    // line_end marks exactly the carriage return
    `XLF_ASSERT_NOW(a_cr_flag, text_valid, cr_match)
    // A newline is followed at once by the closing carriage return
    `XLF_ASSERT_NEXT(a_lf_then_cr, lf_take, text_valid && line_end)
    // Input is held back only while output is pending
    `XLF_ASSERT_NOW(a_stall_cause, in_busy, text_valid)

endmodule

bind xyz_sample_ascii_line_formatter xlf_checker u_xlf_checker (.*);
